@@ rtl/core/rttbg_pkg.sv @@
// ----------------------------------------------------------------------------
// rttbg_pkg
// shared widths, register indexes, stage control type and fixed-point
// constants for the root trace token bucket gate
// ----------------------------------------------------------------------------
package rttbg_pkg;

   // field and register widths
   localparam int TIME_BITS = 48;
   localparam int FRAC_BITS = 32;
   localparam int RATE_W    = 40;
   localparam int CAP_W     = 21;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = RATE_W;

   // token count in fixed point, whole part as wide as the capacity register
   localparam int TOK_W = FRAC_BITS + CAP_W;

   // split of the refill product into partial products
   localparam int ELO_W = 32;
   localparam int EHI_W = TIME_BITS - ELO_W;
   localparam int RLO_W = 32;
   localparam int RHI_W = RATE_W - RLO_W;
   localparam int PROD_W = TIME_BITS + RATE_W;

   // saturated refill amount, one bit above the token range
   localparam int ADD_W = TOK_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CAP  = CSR_IDX_W'(1);

   // reset values
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4295);
   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1);

   // one whole token
   localparam logic [TOK_W-1:0] ONE_TOKEN = TOK_W'(1) << FRAC_BITS;

   // per-item flags carried down the pipeline
   typedef struct packed {
      logic root;
      logic inner;
      logic fwd;
   } rttbg_ctl_type;

endpackage

@@ rtl/core/rttbg_front.sv @@
// ----------------------------------------------------------------------------
// rttbg_front
// input register stage: classifies the request, tracks the last refill
// time and computes the elapsed time for forward-moving root requests
// ----------------------------------------------------------------------------
module rttbg_front
   import rttbg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_BITS-1:0] req_timestamp_us,
   input  logic                 req_parent_valid,
   input  logic                 req_inner_sampled,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rttbg_ctl_type        dn_ctl,
   output logic [TIME_BITS-1:0] dn_elapsed
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   rttbg_ctl_type        ctl_ff, ctl_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 take;

   assign req_ready = !valid_ff || dn_ready;
   assign take      = req_valid && req_ready;

   // classify and measure elapsed time against the last refill
   always_comb begin
      ctl_in.root  = !req_parent_valid && req_inner_sampled;
      ctl_in.inner = req_inner_sampled;
      ctl_in.fwd   = ctl_in.root && (req_timestamp_us > last_ff);
      elapsed_in   = req_timestamp_us - last_ff;
      last_in      = last_ff;
      if (take && ctl_in.fwd) begin
         last_in = req_timestamp_us;
      end
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff     <= ctl_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_ctl     = ctl_ff;
   assign dn_elapsed = elapsed_ff;

endmodule

@@ rtl/core/rttbg_mul.sv @@
// ----------------------------------------------------------------------------
// rttbg_mul
// two-stage refill multiplier: partial products of elapsed time and rate,
// then their sum saturated just above the token range
// ----------------------------------------------------------------------------
module rttbg_mul
   import rttbg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rttbg_ctl_type        up_ctl,
   input  logic [TIME_BITS-1:0] up_elapsed,
   input  logic [RATE_W-1:0]    rate,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rttbg_ctl_type        dn_ctl,
   output logic [ADD_W-1:0]     dn_add
);

   logic                     pp_valid_ff, pp_valid_in;
   rttbg_ctl_type            pp_ctl_ff;
   logic [ELO_W+RLO_W-1:0]   pp0_ff, pp0_in;
   logic [ELO_W+RHI_W-1:0]   pp1_ff, pp1_in;
   logic [EHI_W+RLO_W-1:0]   pp2_ff, pp2_in;
   logic [EHI_W+RHI_W-1:0]   pp3_ff, pp3_in;
   logic                     sum_valid_ff, sum_valid_in;
   rttbg_ctl_type            sum_ctl_ff;
   logic [ADD_W-1:0]         add_ff, add_in;
   logic [PROD_W-1:0]        prod;
   logic                     sum_ready, pp_ready;
   logic                     pp_take, sum_take;

   assign sum_ready = !sum_valid_ff || dn_ready;
   assign pp_ready  = !pp_valid_ff || sum_ready;
   assign up_ready  = pp_ready;
   assign pp_take   = up_valid && pp_ready;
   assign sum_take  = pp_valid_ff && sum_ready;

   // partial products, none wider than 32 by 32
   always_comb begin
      pp0_in = (ELO_W+RLO_W)'(up_elapsed[ELO_W-1:0]) *
               (ELO_W+RLO_W)'(rate[RLO_W-1:0]);
      pp1_in = (ELO_W+RHI_W)'(up_elapsed[ELO_W-1:0]) *
               (ELO_W+RHI_W)'(rate[RATE_W-1:RLO_W]);
      pp2_in = (EHI_W+RLO_W)'(up_elapsed[TIME_BITS-1:ELO_W]) *
               (EHI_W+RLO_W)'(rate[RLO_W-1:0]);
      pp3_in = (EHI_W+RHI_W)'(up_elapsed[TIME_BITS-1:ELO_W]) *
               (EHI_W+RHI_W)'(rate[RATE_W-1:RLO_W]);
   end

   // sum of partials, saturated at one past the largest token count
   always_comb begin
      prod = PROD_W'(pp0_ff)
           + (PROD_W'(pp1_ff) << RLO_W)
           + (PROD_W'(pp2_ff) << ELO_W)
           + (PROD_W'(pp3_ff) << (ELO_W + RLO_W));
      if (|prod[PROD_W-1:TOK_W]) begin
         add_in = ADD_W'(1) << TOK_W;
      end else begin
         add_in = ADD_W'(prod[TOK_W-1:0]);
      end
   end

   // stage valids
   always_comb begin
      pp_valid_in = pp_valid_ff;
      if (pp_take) begin
         pp_valid_in = 1'b1;
      end else if (sum_ready) begin
         pp_valid_in = 1'b0;
      end
      sum_valid_in = sum_valid_ff;
      if (sum_take) begin
         sum_valid_in = 1'b1;
      end else if (dn_ready) begin
         sum_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff  <= pp_valid_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pp_take) begin
         pp_ctl_ff <= up_ctl;
         pp0_ff    <= pp0_in;
         pp1_ff    <= pp1_in;
         pp2_ff    <= pp2_in;
         pp3_ff    <= pp3_in;
      end
      if (sum_take) begin
         sum_ctl_ff <= pp_ctl_ff;
         add_ff     <= add_in;
      end
   end

   assign dn_valid = sum_valid_ff;
   assign dn_ctl   = sum_ctl_ff;
   assign dn_add   = add_ff;

endmodule

@@ rtl/core/rttbg_bucket.sv @@
// ----------------------------------------------------------------------------
// rttbg_bucket
// token bucket state: refill with saturation at capacity, spend one token,
// and the result register
// ----------------------------------------------------------------------------
module rttbg_bucket
   import rttbg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  rttbg_ctl_type    up_ctl,
   input  logic [ADD_W-1:0] up_add,
   input  logic [CAP_W-1:0] capacity,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_sampled,
   output logic             rsp_limited
);

   logic             valid_ff, valid_in;
   logic [TOK_W-1:0] tokens_ff, tokens_in;
   logic             sampled_ff, sampled_in;
   logic             limited_ff, limited_in;
   logic [CAP_W-1:0] cap_eff;
   logic [TOK_W-1:0] cap_fix;
   logic [TOK_W+1:0] sum;
   logic [TOK_W-1:0] refilled;
   logic             take;

   assign up_ready = !valid_ff || rsp_ready;
   assign take     = up_valid && up_ready;

   // refill, clamp and spend
   always_comb begin
      cap_eff  = (capacity == '0) ? CAP_W'(1) : capacity;
      cap_fix  = {cap_eff, {FRAC_BITS{1'b0}}};
      sum      = (TOK_W+2)'(tokens_ff) + (TOK_W+2)'(up_add);
      refilled = tokens_ff;
      if (up_ctl.fwd) begin
         if (sum >= (TOK_W+2)'(cap_fix)) begin
            refilled = cap_fix;
         end else begin
            refilled = sum[TOK_W-1:0];
         end
      end
      tokens_in  = tokens_ff;
      sampled_in = up_ctl.inner;
      limited_in = 1'b0;
      if (up_ctl.root) begin
         if (refilled < ONE_TOKEN) begin
            tokens_in  = refilled;
            sampled_in = 1'b0;
            limited_in = 1'b1;
         end else begin
            tokens_in  = refilled - ONE_TOKEN;
            sampled_in = 1'b1;
         end
      end
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // bucket starts full at the reset capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tokens_ff <= {CAP_RESET, {FRAC_BITS{1'b0}}};
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            tokens_ff <= tokens_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (take) begin
         sampled_ff <= sampled_in;
         limited_ff <= limited_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_sampled = sampled_ff;
   assign rsp_limited = limited_ff;

endmodule

@@ rtl/core/root_trace_token_bucket_gate.sv @@
// ----------------------------------------------------------------------------
// root_trace_token_bucket_gate
// rate limiter for root sampling decisions built on a fixed-point token bucket
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ channel (valid/ready) with a microsecond time
//   stamp, a parent-valid flag and the wrapped sampler's verdict. Each request
//   gives exactly one result on the rsp_ channel: sampled and limited.
//   Requests with a valid parent, or already dropped, pass through and leave
//   the bucket alone; root requests refill the bucket by elapsed time times
//   the rate (time must move forward), clamp at capacity, and spend a token.
//   The transfer loads the input register; the request then moves through the
//   partial product register, the product sum register and the bucket and
//   result register, which makes the result valid.
//   Throughput is one request per cycle while the receiver accepts results,
//   set by the token update loop in the bucket stage.
//   The csr_ port writes rate_per_us (index 0) and bucket_capacity (index 1)
//   with no wait state; write only while the pipeline is empty.
//   Reset sets rate 4295, capacity 1, a full bucket and last time zero.
//   When the receiver stalls, results hold in the output register and the
//   pipeline fills up before req_ready drops.
// ----------------------------------------------------------------------------
module root_trace_token_bucket_gate
   import rttbg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_BITS-1:0]  req_timestamp_us,
   input  logic                  req_parent_valid,
   input  logic                  req_inner_sampled,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_sampled,
   output logic                  rsp_limited,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RATE_W-1:0]    rate_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic                 fr_valid, fr_ready;
   rttbg_ctl_type        fr_ctl;
   logic [TIME_BITS-1:0] fr_elapsed;
   logic                 mu_valid, mu_ready;
   rttbg_ctl_type        mu_ctl;
   logic [ADD_W-1:0]     mu_add;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE: rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_CAP:  cap_ff  <= csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input stage and time tracking
   rttbg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timestamp_us  (req_timestamp_us),
      .req_parent_valid  (req_parent_valid),
      .req_inner_sampled (req_inner_sampled),
      .dn_valid          (fr_valid),
      .dn_ready          (fr_ready),
      .dn_ctl            (fr_ctl),
      .dn_elapsed        (fr_elapsed)
   );

   // refill product
   rttbg_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (fr_valid),
      .up_ready   (fr_ready),
      .up_ctl     (fr_ctl),
      .up_elapsed (fr_elapsed),
      .rate       (rate_ff),
      .dn_valid   (mu_valid),
      .dn_ready   (mu_ready),
      .dn_ctl     (mu_ctl),
      .dn_add     (mu_add)
   );

   // bucket and result
   rttbg_bucket u_bucket (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (mu_valid),
      .up_ready    (mu_ready),
      .up_ctl      (mu_ctl),
      .up_add      (mu_add),
      .capacity    (cap_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sampled (rsp_sampled),
      .rsp_limited (rsp_limited)
   );

endmodule

@@ tb/sv/root_trace_token_bucket_gate_test.sv @@
// ----------------------------------------------------------------------------
// root_trace_token_bucket_gate_test
// self-checking bench for the root trace token bucket gate
// ----------------------------------------------------------------------------
// Requests are fed through a valid/ready driver from a queue of pending
// requests. A bucket predictor computes each expected decision at the
// transfer. A monitor compares every result transfer with the oldest
// expected decision. A short directed sequence comes first: pass-through
// forms, equal and earlier time stamps, refill overflow, a lowered capacity,
// zero rate, zero capacity and ignored register indexes. Random phases follow
// under several rate and capacity settings and several idle and stall mixes.
// ----------------------------------------------------------------------------
module root_trace_token_bucket_gate_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rttbg_pkg::*;

   typedef struct packed {
      logic [TIME_BITS-1:0] timestamp_us;
      logic                 parent_valid;
      logic                 inner_sampled;
   } sample_req_type;

   typedef struct packed {
      logic sampled;
      logic limited;
   } decision_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [RATE_W-1:0]    RATE_MAX = '1;
   localparam logic [CAP_W-1:0]     CAP_MAX  = '1;
   localparam logic [TIME_BITS-1:0] TIME_MID = TIME_BITS'(1) << (TIME_BITS - 1);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MAX = '1;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 180;
   localparam int DRAIN_CYCLES     = 8;

   // dut inputs, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TIME_BITS-1:0]  req_timestamp_us = '0;
   logic                  req_parent_valid = 1'b0;
   logic                  req_inner_sampled = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_sampled;
   logic                  rsp_limited;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // pending requests and expected decisions
   sample_req_type request_q[$];
   decision_type   decision_q[$];

   // predictor copy of configuration and bucket state
   logic [RATE_W-1:0]    rate_cfg = RATE_RESET;
   logic [CAP_W-1:0]     cap_cfg = CAP_RESET;
   logic [63:0]          bucket_level = 64'(ONE_TOKEN);
   logic [TIME_BITS-1:0] last_refill_us = '0;

   // run control and statistics
   int unsigned          send_idle_pct = 0;
   int unsigned          stall_pct = 0;
   logic [TIME_BITS-1:0] ts_cursor = '0;
   int                   errors = 0;
   int                   root_count = 0;
   int                   pass_count = 0;
   int                   kept_count = 0;
   int                   limited_count = 0;
   int                   setting_count = 1;

   root_trace_token_bucket_gate uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timestamp_us  (req_timestamp_us),
      .req_parent_valid  (req_parent_valid),
      .req_inner_sampled (req_inner_sampled),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sampled       (rsp_sampled),
      .rsp_limited       (rsp_limited),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // bucket capacity in fixed point, zero counts as one token
   function automatic logic [63:0] bucket_full();
      logic [63:0] whole;
      whole = (cap_cfg == '0) ? 64'd1 : 64'(cap_cfg);
      return whole << FRAC_BITS;
   endfunction

   // refill, spend and decide for one request; updates the bucket state
   function automatic decision_type gate_decide(sample_req_type r);
      logic [63:0]       full;
      logic [PROD_W-1:0] gain;
      decision_type      d;
      full = bucket_full();
      d.sampled = r.inner_sampled;
      d.limited = 1'b0;
      if (r.parent_valid || !r.inner_sampled) return d;
      // refill only when time moved forward, exact product then clamp
      if (r.timestamp_us > last_refill_us) begin
         gain = PROD_W'(r.timestamp_us - last_refill_us) * PROD_W'(rate_cfg);
         last_refill_us = r.timestamp_us;
         if (bucket_level >= full || gain >= PROD_W'(full - bucket_level))
            bucket_level = full;
         else
            bucket_level = bucket_level + 64'(gain);
      end
      if (bucket_level < 64'(ONE_TOKEN)) begin
         d.sampled = 1'b0;
         d.limited = 1'b1;
      end else begin
         bucket_level = bucket_level - 64'(ONE_TOKEN);
      end
      return d;
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      sample_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            next_req.timestamp_us  = req_timestamp_us;
            next_req.parent_valid  = req_parent_valid;
            next_req.inner_sampled = req_inner_sampled;
            decision_q.push_back(gate_decide(next_req));
            if (!req_parent_valid && req_inner_sampled) root_count++;
            else pass_count++;
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = request_q.pop_front();
               req_valid         <= 1'b1;
               req_timestamp_us  <= next_req.timestamp_us;
               req_parent_valid  <= next_req.parent_valid;
               req_inner_sampled <= next_req.inner_sampled;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      decision_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decision_q.size() == 0) begin
               $error("result transfer with no decision expected");
               errors++;
            end else begin
               want = decision_q.pop_front();
               if (rsp_sampled !== want.sampled) begin
                  $error("sampled: expected %0b, actual %0b", want.sampled, rsp_sampled);
                  errors++;
               end
               if (rsp_limited !== want.limited) begin
                  $error("limited: expected %0b, actual %0b", want.limited, rsp_limited);
                  errors++;
               end
            end
            if (rsp_sampled === 1'b1) kept_count++;
            if (rsp_limited === 1'b1) limited_count++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic queue_req(input logic [TIME_BITS-1:0] ts, input logic parent,
                            input logic inner);
      sample_req_type r;
      r.timestamp_us  = ts;
      r.parent_valid  = parent;
      r.inner_sampled = inner;
      request_q.push_back(r);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_RATE) rate_cfg = data[RATE_W-1:0];
      else if (idx == CSR_CAP) cap_cfg = data[CAP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // new rate and capacity, junk above the capacity field, one ignored index
   task automatic apply_setting(input logic [RATE_W-1:0] rate,
                                input logic [CAP_W-1:0] cap);
      csr_write(CSR_IDX_W'($urandom_range(CSR_IDX_MAX, CSR_CAP + 1)),
                CSR_DATA_W'({$urandom, $urandom}));
      csr_write(CSR_RATE, CSR_DATA_W'(rate));
      csr_write(CSR_CAP, {(CSR_DATA_W - CAP_W)'($urandom), cap});
      setting_count++;
   endtask

   // let every queued request transfer and every result come back
   task automatic drain();
      while (request_q.size() > 0 || decision_q.size() > 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 55;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 55;
         end
         default: begin
            send_idle_pct = 16;
            stall_pct = 16;
         end
      endcase
   endtask

   // mostly root requests with time moving forward near the token pace
   task automatic queue_random(input int count);
      logic [63:0]          pace;
      logic [63:0]          delta;
      logic [TIME_BITS-1:0] ts;
      int unsigned          pick;
      logic                 parent;
      pace = 64'(ONE_TOKEN) / ((rate_cfg == '0) ? 64'd1 : 64'(rate_cfg));
      if (pace == '0) pace = 64'd1;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            // root request: burst, paced step, long gap or earlier stamp
            if (pick < 14) delta = '0;
            else if (pick < 66) delta = {$urandom, $urandom} % (2 * pace + 1);
            else if (pick < 74) delta = pace * $urandom_range(40, 2);
            else delta = '0;
            ts_cursor = ts_cursor + TIME_BITS'(delta);
            ts = ts_cursor;
            if (pick >= 74) ts = ts_cursor - TIME_BITS'($urandom_range(1000, 1));
            queue_req(ts, 1'b0, 1'b1);
         end else begin
            // pass-through request with any time stamp
            parent = 1'($urandom_range(1));
            queue_req(TIME_BITS'({$urandom, $urandom}), parent,
                      parent ? 1'(($urandom_range(1))) : 1'b0);
         end
      end
   endtask

   // stimulus and final verdict
   initial begin
      logic [RATE_W-1:0] rate;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting: one token, slow refill
      queue_req('0, 1'b0, 1'b1);
      queue_req('0, 1'b0, 1'b1);
      queue_req(TIME_MAX, 1'b1, 1'b1);
      queue_req('0, 1'b1, 1'b0);
      queue_req(TIME_MAX, 1'b0, 1'b0);
      queue_req(TIME_BITS'(1000000), 1'b0, 1'b1);
      queue_req(TIME_BITS'(999999), 1'b0, 1'b1);
      queue_req(TIME_BITS'(1000000), 1'b0, 1'b1);
      drain();

      // widest rate and capacity, refill product far past 64 bits
      apply_setting(RATE_MAX, CAP_MAX);
      queue_req(TIME_BITS'(1000001), 1'b0, 1'b1);
      queue_req(TIME_MID, 1'b0, 1'b1);
      queue_req(TIME_MID, 1'b0, 1'b1);
      queue_req(TIME_MID, 1'b0, 1'b1);
      drain();

      // zero rate and zero capacity: clamp from a full bucket, then starve
      apply_setting('0, '0);
      queue_req(TIME_MID + 10, 1'b0, 1'b1);
      queue_req(TIME_MID + 20, 1'b0, 1'b1);
      queue_req(TIME_MID + 20, 1'b1, 1'b1);
      drain();

      // one token per microsecond, time stamp kept while the rate was zero
      apply_setting(RATE_W'(ONE_TOKEN), CAP_W'(2));
      queue_req(TIME_MID + 21, 1'b0, 1'b1);
      queue_req(TIME_MID + 21, 1'b0, 1'b1);
      queue_req(TIME_MID + 1000, 1'b0, 1'b1);
      queue_req(TIME_MID + 1000, 1'b0, 1'b1);
      queue_req(TIME_MID + 1000, 1'b0, 1'b1);
      queue_req(TIME_MID + 1000, 1'b1, 1'b0);
      drain();
      ts_cursor = TIME_MID + 1000;

      // random phases over several settings and idle mixes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         rate = RATE_W'({$urandom, $urandom}) >> $urandom_range(RATE_W - 1);
         case (p)
            0: apply_setting(RATE_MAX, CAP_MAX);
            1: apply_setting(RATE_W'(1), CAP_W'(1));
            2: apply_setting('0, '0);
            3: apply_setting(RATE_RESET, CAP_RESET);
            4: apply_setting(RATE_W'(ONE_TOKEN), CAP_W'(4));
            5: apply_setting(rate, CAP_W'($urandom_range(16, 1)));
            6: apply_setting(rate, CAP_W'(1048576));
            default: apply_setting(rate, CAP_W'($urandom));
         endcase
         set_idle(idle_mode_type'(p % 4));
         queue_random(ITEMS_PER_PHASE);
         drain();
      end

      $display("covered %0d root and %0d pass-through requests over %0d settings",
               root_count, pass_count, setting_count);
      $display("results: %0d kept, %0d limited", kept_count, limited_count);
      if (errors == 0 && decision_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rttbg_pkg.sv
rtl/core/rttbg_front.sv
rtl/core/rttbg_mul.sv
rtl/core/rttbg_bucket.sv
rtl/core/root_trace_token_bucket_gate.sv
tb/sv/root_trace_token_bucket_gate_test.sv
